// ----- rtl/keyboard_scancode_decoder_defines.svh -----
// Assertion macros used by the keyboard scancode decoder checker.
`ifndef KEYBOARD_SCANCODE_DECODER_DEFINES_SVH
`define KEYBOARD_SCANCODE_DECODER_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled in reset.
`define KSD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and disabled in reset.
`define KSD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/kbd_pkg.sv -----
// Shared types, scancode constants and US layout tables for the scancode decoder.
`default_nettype none

package kbd_pkg;

  localparam logic [7:0] SC_PREFIX = 8'hE0;
  localparam logic [6:0] SC_LSHIFT = 7'h2A;
  localparam logic [6:0] SC_RSHIFT = 7'h36;
  localparam logic [6:0] SC_CTRL   = 7'h1D;
  localparam logic [6:0] SC_CAPS   = 7'h3A;
  localparam logic [6:0] CASE_OFFSET = 7'd32;
  localparam logic [6:0] CHAR_LOWER_A = 7'h61;
  localparam logic [6:0] CHAR_LOWER_Z = 7'h7A;

  typedef struct packed {
    logic shift;
    logic ctrl;
    logic caps;
    logic prefix;
  } flags_t;

  // Decoded outcome of one accepted word, with the modifier snapshot.
  typedef struct packed {
    logic emit;
    logic ext;
    logic ctrl;
    logic shift;
    logic caps;
  } key_event_t;

  function automatic logic [6:0] plain_char(input logic [6:0] code);
    logic [6:0] c;
    c = 7'h00;
    case (code)
      7'd1:  c = 7'h1B; 7'd2:  c = 7'h31; 7'd3:  c = 7'h32; 7'd4:  c = 7'h33;
      7'd5:  c = 7'h34; 7'd6:  c = 7'h35; 7'd7:  c = 7'h36; 7'd8:  c = 7'h37;
      7'd9:  c = 7'h38; 7'd10: c = 7'h39; 7'd11: c = 7'h30; 7'd12: c = 7'h2D;
      7'd13: c = 7'h3D; 7'd14: c = 7'h08; 7'd15: c = 7'h09; 7'd16: c = 7'h71;
      7'd17: c = 7'h77; 7'd18: c = 7'h65; 7'd19: c = 7'h72; 7'd20: c = 7'h74;
      7'd21: c = 7'h79; 7'd22: c = 7'h75; 7'd23: c = 7'h69; 7'd24: c = 7'h6F;
      7'd25: c = 7'h70; 7'd26: c = 7'h5B; 7'd27: c = 7'h5D; 7'd28: c = 7'h0A;
      7'd30: c = 7'h61; 7'd31: c = 7'h73; 7'd32: c = 7'h64; 7'd33: c = 7'h66;
      7'd34: c = 7'h67; 7'd35: c = 7'h68; 7'd36: c = 7'h6A; 7'd37: c = 7'h6B;
      7'd38: c = 7'h6C; 7'd39: c = 7'h3B; 7'd40: c = 7'h27; 7'd41: c = 7'h60;
      7'd43: c = 7'h5C; 7'd44: c = 7'h7A; 7'd45: c = 7'h78; 7'd46: c = 7'h63;
      7'd47: c = 7'h76; 7'd48: c = 7'h62; 7'd49: c = 7'h6E; 7'd50: c = 7'h6D;
      7'd51: c = 7'h2C; 7'd52: c = 7'h2E; 7'd53: c = 7'h2F; 7'd55: c = 7'h2A;
      7'd57: c = 7'h20;
      default: c = 7'h00;
    endcase
    return c;
  endfunction

  function automatic logic [6:0] shifted_char(input logic [6:0] code);
    logic [6:0] c;
    c = 7'h00;
    case (code)
      7'd1:  c = 7'h1B; 7'd2:  c = 7'h21; 7'd3:  c = 7'h40; 7'd4:  c = 7'h23;
      7'd5:  c = 7'h24; 7'd6:  c = 7'h25; 7'd7:  c = 7'h5E; 7'd8:  c = 7'h26;
      7'd9:  c = 7'h2A; 7'd10: c = 7'h28; 7'd11: c = 7'h29; 7'd12: c = 7'h5F;
      7'd13: c = 7'h2B; 7'd14: c = 7'h08; 7'd15: c = 7'h09; 7'd16: c = 7'h51;
      7'd17: c = 7'h57; 7'd18: c = 7'h45; 7'd19: c = 7'h52; 7'd20: c = 7'h54;
      7'd21: c = 7'h59; 7'd22: c = 7'h55; 7'd23: c = 7'h49; 7'd24: c = 7'h4F;
      7'd25: c = 7'h50; 7'd26: c = 7'h7B; 7'd27: c = 7'h7D; 7'd28: c = 7'h0A;
      7'd30: c = 7'h41; 7'd31: c = 7'h53; 7'd32: c = 7'h44; 7'd33: c = 7'h46;
      7'd34: c = 7'h47; 7'd35: c = 7'h48; 7'd36: c = 7'h4A; 7'd37: c = 7'h4B;
      7'd38: c = 7'h4C; 7'd39: c = 7'h3A; 7'd40: c = 7'h22; 7'd41: c = 7'h7E;
      7'd43: c = 7'h7C; 7'd44: c = 7'h5A; 7'd45: c = 7'h58; 7'd46: c = 7'h43;
      7'd47: c = 7'h56; 7'd48: c = 7'h42; 7'd49: c = 7'h4E; 7'd50: c = 7'h4D;
      7'd51: c = 7'h3C; 7'd52: c = 7'h3E; 7'd53: c = 7'h3F; 7'd55: c = 7'h2A;
      7'd57: c = 7'h20;
      default: c = 7'h00;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/kbd_rom.sv -----
// Layout table memory with a registered read port for plain and shifted characters.
`default_nettype none

module kbd_rom (
  input  wire logic       clk,
  input  wire logic       rd_en,
  input  wire logic [6:0] rd_addr,
  output logic      [6:0] plain_data,
  output logic      [6:0] shifted_data
);

  logic [13:0] rd_word;

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_word <= {kbd_pkg::shifted_char(rd_addr), kbd_pkg::plain_char(rd_addr)};
    end
  end

  assign plain_data   = rd_word[6:0];
  assign shifted_data = rd_word[13:7];

endmodule

`default_nettype wire

// ----- rtl/kbd_flags.sv -----
// Modifier flag word: decodes each accepted byte and updates shift, ctrl, caps and prefix.
`default_nettype none

module kbd_flags (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               accept,
  input  wire logic [7:0]         scan_code,
  output kbd_pkg::key_event_t     key_event
);

  kbd_pkg::flags_t flags;
  kbd_pkg::flags_t flags_next;
  logic [6:0]      base;

  assign base = scan_code[6:0];

  always_comb begin
    flags_next      = flags;
    key_event       = '0;
    key_event.ext   = flags.prefix;
    key_event.ctrl  = flags.ctrl;
    key_event.shift = flags.shift;
    key_event.caps  = flags.caps;
    if (scan_code == kbd_pkg::SC_PREFIX) begin
      flags_next.prefix = 1'b1;
    end else if (scan_code[7]) begin
      // Release words only drop modifiers and the pending prefix.
      flags_next.prefix = 1'b0;
      case (base) inside
        kbd_pkg::SC_LSHIFT, kbd_pkg::SC_RSHIFT: flags_next.shift = 1'b0;
        kbd_pkg::SC_CTRL:                       flags_next.ctrl  = 1'b0;
        default: ;
      endcase
    end else begin
      flags_next.prefix = 1'b0;
      case (base) inside
        kbd_pkg::SC_LSHIFT, kbd_pkg::SC_RSHIFT: flags_next.shift = 1'b1;
        kbd_pkg::SC_CTRL:                       flags_next.ctrl  = 1'b1;
        kbd_pkg::SC_CAPS:                       flags_next.caps  = ~flags.caps;
        default:                                key_event.emit   = 1'b1;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      flags <= '0;
    end else if (accept) begin
      flags <= flags_next;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/keyboard_scancode_decoder.sv -----
// Top level of the set 1 scancode to key event decoder.
`default_nettype none

// Takes one scancode set 1 byte per cycle and turns key presses into key events with a
// US layout character, the extended flag and the ctrl and shift state at the time of the
// press. Prefix, release, shift, ctrl and caps lock bytes update the modifier flags and
// give no event. A byte is taken every cycle while the output side keeps up; an event
// passes through the registered read of the layout table memory and then the output
// register. The modifier flags update in the cycle a byte is taken, so back-to-back
// bytes see each other's effect without a bubble.
module keyboard_scancode_decoder (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] scan_code,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic      [6:0] key_code,
  output logic      [6:0] ascii_char,
  output logic            extended_key,
  output logic            ctrl_active,
  output logic            shift_active
);

  kbd_pkg::key_event_t key_event;
  kbd_pkg::key_event_t s1_event;
  logic       accept;
  logic       s1_valid;
  logic       s1_adv;
  logic [6:0] s1_code;
  logic [6:0] plain_data;
  logic [6:0] shifted_data;
  logic [6:0] table_char;
  logic [6:0] char_next;

  assign s1_adv   = !out_valid || !out_stall;
  assign in_stall = rst || (s1_valid && !s1_adv);
  assign accept   = in_valid && !in_stall;

  kbd_flags u_flags (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .scan_code (scan_code),
    .key_event (key_event)
  );

  kbd_rom u_rom (
    .clk          (clk),
    .rd_en        (accept),
    .rd_addr      (scan_code[6:0]),
    .plain_data   (plain_data),
    .shifted_data (shifted_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= key_event.emit;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_code  <= scan_code[6:0];
      s1_event <= key_event;
    end
  end

  // Caps lock raises letters only while shift is up; extended keys carry no character.
  always_comb begin
    table_char = s1_event.shift ? shifted_data : plain_data;
    char_next  = table_char;
    if (s1_event.caps && !s1_event.shift && table_char >= kbd_pkg::CHAR_LOWER_A
        && table_char <= kbd_pkg::CHAR_LOWER_Z) begin
      char_next = table_char - kbd_pkg::CASE_OFFSET;
    end
    if (s1_event.ext) begin
      char_next = 7'h00;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && s1_adv) begin
      key_code     <= s1_code;
      ascii_char   <= char_next;
      extended_key <= s1_event.ext;
      ctrl_active  <= s1_event.ctrl;
      shift_active <= s1_event.shift;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/kbd_checker.sv -----
// Port-level checker for the scancode decoder and its bind to the top level.
`default_nettype none
`include "keyboard_scancode_decoder_defines.svh"

module kbd_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_valid,
  input wire logic       in_stall,
  input wire logic [7:0] scan_code,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic [6:0] key_code,
  input wire logic [6:0] ascii_char,
  input wire logic       extended_key,
  input wire logic       ctrl_active,
  input wire logic       shift_active
);

  logic in_accept;
  logic lower_char;

  assign in_accept  = in_valid && !in_stall;
  assign lower_char = ascii_char >= kbd_pkg::CHAR_LOWER_A
                      && ascii_char <= kbd_pkg::CHAR_LOWER_Z;

  `KSD_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "stalled word dropped")
  `KSD_ASSERT_NOW(a_ext_no_char, out_valid && extended_key, ascii_char == 7'h00, "extended char")
  `KSD_ASSERT_NOW(a_shift_lower, out_valid && shift_active, !lower_char, "shift lowercase")
  `KSD_ASSERT_NOW(a_event_src, $rose(out_valid), $past(in_accept, 2), "event without byte")

endmodule

bind keyboard_scancode_decoder kbd_checker u_kbd_checker (.*);

`default_nettype wire

// ----- bench/keyboard_scancode_decoder_test.sv -----
// Self-checking testbench for the set 1 scancode to key event decoder.
module keyboard_scancode_decoder_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT  = 500000;
  localparam int unsigned DRAIN_CYCLES = 10;
  localparam int unsigned RANDOM_WORDS = 800;
  localparam int unsigned LAYOUT_SIZE  = 58;
  localparam int unsigned MAX_REPORTS  = 10;

  typedef struct packed {
    logic [6:0] key_code;
    logic [6:0] ascii_char;
    logic       extended_key;
    logic       ctrl_active;
    logic       shift_active;
  } pressed_key_t;

  // US layout, indexed by make code; zero marks a key without a character.
  localparam logic [7:0] PLAIN_LAYOUT [0:LAYOUT_SIZE-1] = '{
    8'd0, 8'd27, "1", "2", "3", "4", "5", "6", "7", "8", "9", "0", "-", "=", 8'd8,
    8'd9, "q", "w", "e", "r", "t", "y", "u", "i", "o", "p", "[", "]", 8'd10, 8'd0,
    "a", "s", "d", "f", "g", "h", "j", "k", "l", ";", "'", 8'h60, 8'd0, "\\",
    "z", "x", "c", "v", "b", "n", "m", ",", ".", "/", 8'd0, "*", 8'd0, " "
  };

  localparam logic [7:0] SHIFTED_LAYOUT [0:LAYOUT_SIZE-1] = '{
    8'd0, 8'd27, "!", "@", "#", "$", "%", "^", "&", "*", "(", ")", "_", "+", 8'd8,
    8'd9, "Q", "W", "E", "R", "T", "Y", "U", "I", "O", "P", "{", "}", 8'd10, 8'd0,
    "A", "S", "D", "F", "G", "H", "J", "K", "L", ":", "\"", "~", 8'd0, "|",
    "Z", "X", "C", "V", "B", "N", "M", "<", ">", "?", 8'd0, "*", 8'd0, " "
  };

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] scan_code = 8'h00;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [6:0] key_code;
  logic [6:0] ascii_char;
  logic       extended_key;
  logic       ctrl_active;
  logic       shift_active;

  // Modifier state as the decoder should hold it after each accepted word.
  logic shift_held = 1'b0;
  logic ctrl_held  = 1'b0;
  logic caps_lock  = 1'b0;
  logic ext_armed  = 1'b0;

  logic [7:0]   scan_queue[$];
  pressed_key_t expected_keys[$];

  logic        word_taken = 1'b0;
  int unsigned gap_left = 0;
  int unsigned stall_left = 0;
  int unsigned stall_pick;
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;

  keyboard_scancode_decoder uut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .scan_code    (scan_code),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .key_code     (key_code),
    .ascii_char   (ascii_char),
    .extended_key (extended_key),
    .ctrl_active  (ctrl_active),
    .shift_active (shift_active)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic logic [6:0] layout_char(input logic [6:0] make);
    logic [7:0] chr;
    chr = 8'd0;
    if (make < LAYOUT_SIZE) begin
      chr = shift_held ? SHIFTED_LAYOUT[make] : PLAIN_LAYOUT[make];
    end
    // Caps lock only affects letters, and only while shift is up.
    if (caps_lock && !shift_held && chr[6:0] >= kbd_pkg::CHAR_LOWER_A &&
        chr[6:0] <= kbd_pkg::CHAR_LOWER_Z) begin
      chr[6:0] = chr[6:0] - kbd_pkg::CASE_OFFSET;
    end
    return chr[6:0];
  endfunction

  function automatic void decode_word(input logic [7:0] code);
    pressed_key_t ev;
    logic [6:0]   make;
    make = code[6:0];
    if (code == kbd_pkg::SC_PREFIX) begin
      ext_armed = 1'b1;
    end else if (code[7]) begin
      if (make == kbd_pkg::SC_LSHIFT || make == kbd_pkg::SC_RSHIFT) shift_held = 1'b0;
      if (make == kbd_pkg::SC_CTRL) ctrl_held = 1'b0;
      ext_armed = 1'b0;
    end else if (make == kbd_pkg::SC_LSHIFT || make == kbd_pkg::SC_RSHIFT) begin
      shift_held = 1'b1;
      ext_armed  = 1'b0;
    end else if (make == kbd_pkg::SC_CTRL) begin
      ctrl_held = 1'b1;
      ext_armed = 1'b0;
    end else if (make == kbd_pkg::SC_CAPS) begin
      caps_lock = !caps_lock;
      ext_armed = 1'b0;
    end else begin
      ev.key_code     = make;
      ev.ascii_char   = ext_armed ? 7'd0 : layout_char(make);
      ev.extended_key = ext_armed;
      ev.ctrl_active  = ctrl_held;
      ev.shift_active = shift_held;
      ext_armed = 1'b0;
      expected_keys.push_back(ev);
    end
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Mostly keys with a character, now and then any make code.
  function automatic logic [6:0] pick_key();
    logic [31:0] r;
    if ($urandom_range(0, 4) != 0) r = $urandom_range(1, LAYOUT_SIZE - 1);
    else r = $urandom_range(0, 127);
    return r[6:0];
  endfunction

  function automatic void note_failure(input string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) $display("%s", msg);
  endfunction

  // Input side: a word is accepted when valid is high and stall is low.
  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall) begin
      decode_word(scan_code);
      word_taken = 1'b1;
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || word_taken) begin
      word_taken = 1'b0;
      if (gap_left != 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (scan_queue.size() != 0) begin
        scan_code <= scan_queue.pop_front();
        in_valid  <= 1'b1;
        gap_left = pick_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Output side back-pressure: free stretches mixed with short and long stalls.
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_pick = $urandom_range(0, 99);
      if (stall_pick < 40) begin
        out_stall <= 1'b0;
        stall_left = $urandom_range(1, 30);
      end else begin
        out_stall <= 1'b1;
        if (stall_pick < 88) stall_left = $urandom_range(1, 3);
        else if (stall_pick < 97) stall_left = $urandom_range(4, 12);
        else stall_left = $urandom_range(20, 60);
      end
    end else begin
      stall_left--;
    end
  end

  always @(posedge clk) begin : key_monitor
    pressed_key_t want;
    pressed_key_t got;
    if (!rst && out_valid && !out_stall) begin
      got = '{key_code, ascii_char, extended_key, ctrl_active, shift_active};
      if (expected_keys.size() == 0) begin
        note_failure($sformatf("unexpected key event: code %h char %h ext %b ctrl %b shift %b",
                               got.key_code, got.ascii_char, got.extended_key,
                               got.ctrl_active, got.shift_active));
      end else begin
        want = expected_keys.pop_front();
        if (got !== want) begin
          note_failure($sformatf(
            "key event mismatch: expected code %h char %h ext %b ctrl %b shift %b, got code %h char %h ext %b ctrl %b shift %b",
            want.key_code, want.ascii_char, want.extended_key, want.ctrl_active,
            want.shift_active, got.key_code, got.ascii_char, got.extended_key,
            got.ctrl_active, got.shift_active));
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("keyboard_scancode_decoder_test NOT OK");
      $finish;
    end
  end

  initial begin : stimulus
    int unsigned pick;
    int unsigned reps;
    int unsigned total;
    logic [6:0]  key;
    logic [6:0]  held;
    logic [31:0] r;

    // Directed part: prefix cleared by a foreign release, table edges, control
    // characters, shift and caps interplay, ctrl and extended modifiers.
    scan_queue = '{8'hE0, 8'hFF, 8'h00, 8'h7F, 8'h01, 8'h0E, 8'h0F, 8'h1C, 8'h3B,
                   8'h2A, 8'h02, 8'h3A, 8'h1E, 8'hAA, 8'h1E, 8'h3A,
                   8'h1D, 8'hE0, 8'hE0, 8'h48, 8'h9D,
                   8'hE0, 8'h1D, 8'h20, 8'hE0, 8'h9D,
                   8'hE0, 8'h2A, 8'h10, 8'hAA};
    total = scan_queue.size() + RANDOM_WORDS;

    while (scan_queue.size() < total) begin
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        key = pick_key();
        scan_queue.push_back({1'b0, key});
        if ($urandom_range(0, 3) != 0) scan_queue.push_back({1'b1, key});
      end else if (pick < 55) begin
        held = $urandom_range(0, 1) ? kbd_pkg::SC_LSHIFT : kbd_pkg::SC_RSHIFT;
        scan_queue.push_back({1'b0, held});
        reps = $urandom_range(1, 6);
        repeat (reps) begin
          key = pick_key();
          scan_queue.push_back({1'b0, key});
          scan_queue.push_back({1'b1, key});
        end
        scan_queue.push_back({1'b1, held});
      end else if (pick < 65) begin
        if ($urandom_range(0, 1)) scan_queue.push_back(kbd_pkg::SC_PREFIX);
        scan_queue.push_back({1'b0, kbd_pkg::SC_CTRL});
        reps = $urandom_range(1, 3);
        repeat (reps) scan_queue.push_back({1'b0, pick_key()});
        if ($urandom_range(0, 1)) scan_queue.push_back(kbd_pkg::SC_PREFIX);
        scan_queue.push_back({1'b1, kbd_pkg::SC_CTRL});
      end else if (pick < 72) begin
        scan_queue.push_back({1'b0, kbd_pkg::SC_CAPS});
        scan_queue.push_back({1'b1, kbd_pkg::SC_CAPS});
      end else if (pick < 87) begin
        scan_queue.push_back(kbd_pkg::SC_PREFIX);
        if ($urandom_range(0, 3) == 0) scan_queue.push_back(kbd_pkg::SC_PREFIX);
        r = $urandom_range(0, 127);
        key = r[6:0];
        scan_queue.push_back({1'b0, key});
        if ($urandom_range(0, 1)) begin
          scan_queue.push_back(kbd_pkg::SC_PREFIX);
          scan_queue.push_back({1'b1, key});
        end
      end else begin
        reps = $urandom_range(1, 4);
        repeat (reps) begin
          r = $urandom_range(0, 255);
          scan_queue.push_back(r[7:0]);
        end
      end
    end

    repeat (12) @(negedge clk);
    rst <= 1'b0;

    while (scan_queue.size() != 0 || in_valid) @(posedge clk);
    while (expected_keys.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && expected_keys.size() == 0) begin
      $display("keyboard_scancode_decoder_test OK");
    end else begin
      $display("keyboard_scancode_decoder_test NOT OK");
    end
    $finish;
  end

endmodule
